@@ design/lpc_pkg.sv @@
package lpc_pkg;

    localparam int CAPACITY   = 8;
    localparam int PAGE_W     = 16;
    localparam int SLOT_W     = 3;
    localparam int SLOT_IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef logic [PAGE_W-1:0]     page_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [RANK_W-1:0]     rank_t;

    typedef struct packed {
        page_t [CAPACITY-1:0] pages;
        rank_t [CAPACITY-1:0] ranks;
    } row_t;

endpackage

@@ design/lpc_ram.sv @@
module lpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/lru_page_cache_tag_store.sv @@
// Channel   Handshake          Payload
// --------  -----------------  ------------------------------------------
// command   start / busy       operation, page_number
// result    done (1 cycle)     hit, slot, evicted, evicted_page
//
// The row of the tag RAM is read at the accepting edge. ST_MATCH then compares
// every tag and rank of that row; ST_WRITE updates the ranks and writes the row
// back, or drops every valid bit for a clear, and done is registered from it.
// busy stays high through both, so no new word is taken before done. Reset
// clears the valid bits, not the RAM row; tags and ranks of an invalid entry
// are never used. The receiver cannot stall; done is a single-cycle strobe.
module lru_page_cache_tag_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  lpc_pkg::page_t        page_number,
    output logic                  done,
    output logic                  hit,
    output lpc_pkg::slot_t        slot,
    output logic                  evicted,
    output lpc_pkg::page_t        evicted_page
);

    import lpc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic                op_reg;
    page_t               page_reg;
    logic                hit_reg, full_reg;
    slot_idx_t           slot_idx_reg;
    logic                done_reg, hit_out_reg, evicted_reg;
    slot_t               slot_reg;
    page_t               evicted_page_reg;

    logic                accept;
    logic [$bits(row_t)-1:0] rd_data;
    row_t                rd_row, wr_row;
    logic                we;

    logic [CAPACITY-1:0] hit_vec, free_vec, old_vec;
    slot_idx_t           hit_idx, free_idx, old_idx, pick_idx;
    rank_t               limit;
    logic                evict_now;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign rd_row = row_t'(rd_data);
    assign we     = (state_reg == ST_WRITE) && (op_reg == OP_LOOKUP);

    lpc_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (1)
    ) u_row_ram (
        .clk   (clk),
        .we    (we),
        .waddr ('0),
        .wdata (wr_row),
        .re    (accept),
        .raddr ('0),
        .rdata (rd_data)
    );

    // Compare against every entry at once; lowest slot wins each search.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_vec[i]  = valid_reg[i] && (rd_row.pages[i] == page_reg);
            free_vec[i] = !valid_reg[i];
            old_vec[i]  = valid_reg[i] && (rd_row.ranks[i] == RANK_W'(CAPACITY - 1));
        end
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = SLOT_IDX_W'(i);
            end
            if (free_vec[i])
            begin
                free_idx = SLOT_IDX_W'(i);
            end
            if (old_vec[i])
            begin
                old_idx = SLOT_IDX_W'(i);
            end
        end
        priority if (|hit_vec)
        begin
            pick_idx = hit_idx;
        end
        else if (|free_vec)
        begin
            pick_idx = free_idx;
        end
        else
        begin
            pick_idx = old_idx;
        end
    end

    // Age the entries more recent than a hit one, or every other valid entry on a miss, then write back.
    always_comb
    begin
        limit     = rd_row.ranks[slot_idx_reg];
        evict_now = !hit_reg && full_reg;
        wr_row    = rd_row;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if ((SLOT_IDX_W'(i) != slot_idx_reg) && valid_reg[i] &&
                (!hit_reg || (rd_row.ranks[i] < limit)))
            begin
                wr_row.ranks[i] = rd_row.ranks[i] + RANK_W'(1);
            end
        end
        wr_row.ranks[slot_idx_reg] = '0;
        if (!hit_reg)
        begin
            wr_row.pages[slot_idx_reg] = page_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
                if (op_reg == OP_CLEAR)
                begin
                    valid_next = '0;
                end
                else
                begin
                    valid_next[slot_idx_reg] = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            done_reg  <= (state_reg == ST_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            page_reg <= page_number;
        end
        if (state_reg == ST_MATCH)
        begin
            hit_reg      <= |hit_vec;
            full_reg     <= &valid_reg;
            slot_idx_reg <= pick_idx;
        end
        if (state_reg == ST_WRITE)
        begin
            if (op_reg == OP_CLEAR)
            begin
                hit_out_reg      <= 1'b0;
                slot_reg         <= '0;
                evicted_reg      <= 1'b0;
                evicted_page_reg <= '0;
            end
            else
            begin
                hit_out_reg      <= hit_reg;
                slot_reg         <= SLOT_W'(slot_idx_reg);
                evicted_reg      <= evict_now;
                evicted_page_reg <= evict_now ? rd_row.pages[slot_idx_reg] : '0;
            end
        end
    end

    assign done         = done_reg;
    assign hit          = hit_out_reg;
    assign slot         = slot_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;

`ifndef SYNTHESIS
    a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MATCH))
        else $error("accepted word did not enter compare");

    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_WRITE))
        else $error("done without write-back");

    a_hit_excl_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(hit_out_reg && evicted_reg))
        else $error("hit and eviction reported together");

    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && (op_reg == OP_LOOKUP) && evict_now) |-> (&valid_reg))
        else $error("eviction with a free slot");
`endif

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import lpc_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_WORDS   = 1330;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic  hit;
        slot_t slot;
        logic  evicted;
        page_t evicted_page;
    } lookup_result_t;

    typedef struct {
        logic           op;
        page_t          page;
        bit             typed;
        lookup_result_t res;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    logic  operation;
    page_t page_number;
    logic  done;
    logic  hit;
    slot_t slot;
    logic  evicted;
    page_t evicted_page;

    // shadow copy of the tag store
    page_t shadow_page  [CAPACITY];
    bit    shadow_valid [CAPACITY];
    int    shadow_rank  [CAPACITY];

    lookup_result_t awaited_results[$];
    stim_row_t      directed_rows[$];
    page_t          hot_pages[16];
    int             hot_count;
    int             mismatches = 0;
    int             cycles = 0;

    lru_page_cache_tag_store u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .page_number  (page_number),
        .done         (done),
        .hit          (hit),
        .slot         (slot),
        .evicted      (evicted),
        .evicted_page (evicted_page)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic lookup_result_t cache_access(logic op, page_t pg);
        lookup_result_t r;
        int             way;
        int             limit;
        bit             found;
        bit             free_found;
        r          = '0;
        way        = 0;
        limit      = 0;
        found      = 1'b0;
        free_found = 1'b0;
        if (op == OP_CLEAR)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_rank[i]  = 0;
            end
            return r;
        end
        for (int i = 0; i < CAPACITY && !found; i++)
        begin
            if (shadow_valid[i] && shadow_page[i] == pg)
            begin
                way   = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            // only entries more recent than the hit one age
            limit = shadow_rank[way];
        end
        else
        begin
            limit = CAPACITY + 256;
            for (int i = 0; i < CAPACITY && !free_found; i++)
            begin
                if (!shadow_valid[i])
                begin
                    way        = i;
                    free_found = 1'b1;
                end
            end
            if (!free_found)
            begin
                // oldest entry goes; lowest slot wins a tie
                way = 0;
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (shadow_rank[i] > shadow_rank[way])
                        way = i;
                end
                r.evicted      = 1'b1;
                r.evicted_page = shadow_page[way];
            end
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i != way && shadow_valid[i] && shadow_rank[i] < limit)
                shadow_rank[i] = shadow_rank[i] + 1;
        end
        shadow_rank[way]  = 0;
        shadow_valid[way] = 1'b1;
        if (!found)
            shadow_page[way] = pg;
        r.hit  = found;
        r.slot = slot_t'(way);
        return r;
    endfunction

    function automatic int pick_gap(bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(logic op, page_t pg, bit typed, logic h, slot_t s, logic ev,
                           page_t evpg);
        stim_row_t row;
        row.op                   = op;
        row.page                 = pg;
        row.typed                = typed;
        row.res.hit              = h;
        row.res.slot             = s;
        row.res.evicted          = ev;
        row.res.evicted_page     = evpg;
        directed_rows.push_back(row);
    endtask

    // lower start for the gap given by n and scramble the idle payload
    task automatic idle(int n);
        if (n > 0)
        begin
            @(negedge clk);
            start       <= 1'b0;
            operation   <= logic'($urandom_range(0, 1));
            page_number <= page_t'($urandom_range(0, 65535));
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_word(logic op, page_t pg, bit typed, lookup_result_t typed_res);
        lookup_result_t predicted;
        @(negedge clk);
        start       <= 1'b1;
        operation   <= op;
        page_number <= pg;
        do
            @(posedge clk);
        while (busy);
        predicted = cache_access(op, pg);
        awaited_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        lookup_result_t got;
        lookup_result_t want;
        if (rst_n && done)
        begin
            got = {hit, slot, evicted, evicted_page};
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: hit=%0b slot=%0d evicted=%0b evicted_page=%h",
                             hit, slot, evicted, evicted_page);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.hit !== want.hit || got.slot !== want.slot ||
                    got.evicted !== want.evicted || got.evicted_page !== want.evicted_page)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected hit=%0b slot=%0d evicted=%0b ",
                                  "evicted_page=%h, got hit=%0b slot=%0d evicted=%0b ",
                                  "evicted_page=%h"},
                                 want.hit, want.slot, want.evicted, want.evicted_page,
                                 got.hit, got.slot, got.evicted, got.evicted_page);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == TIMEOUT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int    roll;
        bit    quiet;
        page_t pg;
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = OP_LOOKUP;
        page_number = '0;
        hot_count   = 1;
        quiet       = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end

        // fill, hit, evict the oldest, clear, refill
        add_row(OP_LOOKUP, 16'h0000, 1, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'hFFFF, 1, 1'b0, 3'd1, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h0000, 1, 1'b1, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h0001, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h0002, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h8000, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h5555, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'hAAAA, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h1234, 1, 1'b0, 3'd7, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h4321, 1, 1'b0, 3'd1, 1'b1, 16'hFFFF);
        add_row(OP_LOOKUP, 16'h0001, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h7FFF, 1, 1'b0, 3'd0, 1'b1, 16'h0000);
        add_row(OP_LOOKUP, 16'h1234, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h9999, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_CLEAR,  16'hFFFF, 1, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h4321, 1, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_CLEAR,  16'h0000, 1, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_CLEAR,  16'h5A5A, 1, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'hFFFF, 1, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'hFFFF, 1, 1'b1, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'h0000, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
        add_row(OP_LOOKUP, 16'hFFFF, 0, 1'b0, 3'd0, 1'b0, 16'h0000);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            idle(pick_gap(1'b0));
            send_word(directed_rows[i].op, directed_rows[i].page, directed_rows[i].typed,
                      directed_rows[i].res);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // new working set: some fit in the store, some thrash it
            if (n % 150 == 0)
            begin
                hot_count = $urandom_range(3, 16);
                for (int k = 0; k < 16; k++)
                    hot_pages[k] = page_t'($urandom_range(0, 65535));
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (n == 400 || n == 900)
                drain();
            roll = $urandom_range(0, 99);
            if (roll < 3)
                pg = page_t'($urandom_range(0, 65535));
            else if (roll < 85)
                pg = hot_pages[$urandom_range(0, hot_count - 1)];
            else
                pg = page_t'($urandom_range(0, 65535));
            idle(pick_gap(quiet));
            send_word(roll < 3 ? OP_CLEAR : OP_LOOKUP, pg, 1'b0, '0);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/lpc_pkg.sv
design/lpc_ram.sv
design/lru_page_cache_tag_store.sv
sim/tb_top.sv
